// File: rtl/drle_pkg.sv
// Shared types, constants and helper functions of the delta run-length encoder.
package drle_pkg;

  localparam int BYTE_W = 8;
  localparam int SPAN_W = 21;
  localparam int NSEG   = 3;

  localparam logic [BYTE_W-1:0] RUN_MARK   = 8'hFF;
  localparam logic [BYTE_W-1:0] CHUNK_MAX  = 8'd255;
  localparam logic [BYTE_W-1:0] MIN_RUN    = 8'd4;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 21'd1048576;

  // One piece of an output burst: a marked group (mark, count, value)
  // or a few literal copies of one value.
  typedef enum logic [1:0] {
    SEG_NONE  = 2'd0,
    SEG_GROUP = 2'd1,
    SEG_LIT   = 2'd2
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t         kind;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] val;
  } seg_t;

  // Everything one input beat emits: flushed run, full chunk, final flush.
  typedef struct packed {
    seg_t [NSEG-1:0] seg;
    logic            fin;
  } burst_t;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } seg_pick_t;

  function automatic seg_t flush_seg(logic [BYTE_W-1:0] len, logic [BYTE_W-1:0] val,
                                     logic sent);
    seg_t s;
    s.len = len;
    s.val = val;
    if (len == '0) begin
      s.kind = SEG_NONE;
    end else if (sent || len >= MIN_RUN) begin
      s.kind = SEG_GROUP;
    end else begin
      s.kind = SEG_LIT;
    end
    return s;
  endfunction

  // Lowest non-empty segment at or after the given index.
  function automatic seg_pick_t first_from(seg_t [NSEG-1:0] segs, logic [2:0] start);
    seg_pick_t p;
    p.found = 1'b0;
    p.idx   = 2'd0;
    for (int i = 0; i < NSEG; i++) begin
      if (!p.found && i >= int'(start) && segs[i].kind != SEG_NONE) begin
        p.found = 1'b1;
        p.idx   = 2'(i);
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/drle_step.sv
// Stream state, delta coding and run tracking; builds the burst for each input beat.
module drle_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [drle_pkg::SPAN_W-1:0] cfg_data,
  input  logic                        take,
  input  logic [drle_pkg::BYTE_W-1:0] data_byte,
  input  logic                        final_byte,
  output drle_pkg::burst_t            burst,
  output logic                        has_out
);
  import drle_pkg::*;

  logic [SPAN_W-1:0] delta_span;
  logic              started;
  logic [BYTE_W-1:0] previous_raw;
  logic [BYTE_W-1:0] run_value;
  logic [BYTE_W-1:0] run_length;
  logic              chunk_sent;
  logic [SPAN_W-1:0] position;

  logic              started_next;
  logic [BYTE_W-1:0] previous_raw_next;
  logic [BYTE_W-1:0] run_value_next;
  logic [BYTE_W-1:0] run_length_next;
  logic              chunk_sent_next;
  logic [SPAN_W-1:0] position_next;

  logic              in_span;
  logic [BYTE_W-1:0] val;

  always_comb begin
    in_span           = position < delta_span;
    val               = data_byte;
    started_next      = 1'b1;
    previous_raw_next = previous_raw;
    run_value_next    = run_value;
    run_length_next   = run_length;
    chunk_sent_next   = chunk_sent;
    position_next     = in_span ? position + 1'b1 : position;
    burst.fin         = final_byte;
    for (int i = 0; i < NSEG; i++) begin
      burst.seg[i] = '{kind: SEG_NONE, len: '0, val: '0};
    end

    if (!started) begin
      previous_raw_next = data_byte;
      run_value_next    = data_byte;
      run_length_next   = 8'd1;
      chunk_sent_next   = 1'b0;
    end else begin
      if (in_span) begin
        val               = data_byte - previous_raw;
        previous_raw_next = data_byte;
      end
      if (val == run_value) begin
        run_length_next = run_length + 8'd1;
      end else begin
        burst.seg[0]    = flush_seg(run_length, run_value, chunk_sent);
        run_value_next  = val;
        run_length_next = 8'd1;
        chunk_sent_next = 1'b0;
      end
      // A full chunk goes out at once; the rest of the run follows as a group.
      if (run_length_next == CHUNK_MAX) begin
        burst.seg[1]    = '{kind: SEG_GROUP, len: CHUNK_MAX, val: run_value_next};
        run_length_next = '0;
        chunk_sent_next = 1'b1;
      end
    end

    if (final_byte) begin
      burst.seg[2]      = flush_seg(run_length_next, run_value_next, chunk_sent_next);
      started_next      = 1'b0;
      previous_raw_next = '0;
      run_value_next    = '0;
      run_length_next   = '0;
      chunk_sent_next   = 1'b0;
      position_next     = '0;
    end
  end

  assign has_out = burst.seg[0].kind != SEG_NONE || burst.seg[1].kind != SEG_NONE ||
                   burst.seg[2].kind != SEG_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_span   <= SPAN_RESET;
      started      <= 1'b0;
      previous_raw <= '0;
      run_value    <= '0;
      run_length   <= '0;
      chunk_sent   <= 1'b0;
      position     <= '0;
    end else begin
      if (cfg_we) begin
        delta_span <= cfg_data;
      end
      if (take) begin
        started      <= started_next;
        previous_raw <= previous_raw_next;
        run_value    <= run_value_next;
        run_length   <= run_length_next;
        chunk_sent   <= chunk_sent_next;
        position     <= position_next;
      end
    end
  end

endmodule

// File: rtl/drle_serial.sv
// Burst register and byte serialiser feeding the output register.
module drle_serial (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  drle_pkg::burst_t            burst,
  output logic                        can_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [drle_pkg::BYTE_W-1:0] out_byte,
  output logic                        burst_end,
  output logic                        stream_end
);
  import drle_pkg::*;

  burst_t     desc;
  logic       desc_valid;
  logic [1:0] s;
  logic [1:0] r;
  logic [1:0] b;

  seg_t              cur;
  logic [BYTE_W-1:0] cur_byte;
  logic              rep_done;
  logic              seg_done;
  logic              last;
  logic              out_load;
  seg_pick_t         nxt;
  seg_pick_t         start;

  always_comb begin
    case (s)
      2'd0:    cur = desc.seg[0];
      2'd1:    cur = desc.seg[1];
      default: cur = desc.seg[2];
    endcase
  end

  always_comb begin
    cur_byte = cur.val;
    rep_done = 1'b1;
    seg_done = 1'b1;
    case (cur.kind)
      SEG_GROUP: begin
        cur_byte = (b == 2'd0) ? RUN_MARK : (b == 2'd1) ? cur.len : cur.val;
        rep_done = b == 2'd2;
        seg_done = rep_done;
      end
      SEG_LIT: begin
        // An escaped mark literal takes three bytes: mark, zero, mark.
        if (cur.val == RUN_MARK) begin
          cur_byte = (b == 2'd1) ? '0 : RUN_MARK;
          rep_done = b == 2'd2;
        end
        seg_done = rep_done && ({{(BYTE_W-2){1'b0}}, r} == cur.len - 8'd1);
      end
      default: begin
        cur_byte = '0;
      end
    endcase
    nxt   = first_from(desc.seg, {1'b0, s} + 3'd1);
    start = first_from(burst.seg, 3'd0);
    last  = seg_done && !nxt.found;
  end

  assign out_load = !out_valid || out_ready;
  assign can_take = !desc_valid || (last && out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      out_valid  <= 1'b0;
      s          <= '0;
      r          <= '0;
      b          <= '0;
    end else begin
      if (out_load) begin
        out_valid <= desc_valid;
      end
      if (load) begin
        desc_valid <= 1'b1;
        s          <= start.idx;
        r          <= '0;
        b          <= '0;
      end else if (desc_valid && out_load) begin
        if (seg_done) begin
          s <= nxt.idx;
          r <= '0;
          b <= '0;
        end else if (rep_done) begin
          r <= r + 2'd1;
          b <= '0;
        end else begin
          b <= b + 2'd1;
        end
        if (last) begin
          desc_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= burst;
    end
    if (desc_valid && out_load) begin
      out_byte   <= cur_byte;
      burst_end  <= last;
      stream_end <= last && desc.fin;
    end
  end

endmodule

// File: rtl/delta_rle_encoder.sv
// Top level of the delta plus escaped run-length encoder.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid/in_ready    data_byte, final_byte
//   output    out        out_valid/out_ready  out_byte, burst_end, stream_end
//   config    in         cfg_we               cfg_data (delta span, 21 bits)
//
// Beats that yield at most one output byte stream at one per cycle while the output
// is not stalled; a beat that yields more bytes holds the input until its last byte
// leaves, as the serialiser sends one byte per cycle unless the output stalls.
// A taken beat's burst is registered, then its bytes move to the output register.
// Reset is synchronous and clears the stream state and the span to its default.
// A stalled output holds its byte; the input stalls once the burst register is full.
module delta_rle_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [drle_pkg::SPAN_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [drle_pkg::BYTE_W-1:0] data_byte,
  input  logic                        final_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [drle_pkg::BYTE_W-1:0] out_byte,
  output logic                        burst_end,
  output logic                        stream_end
);
  import drle_pkg::*;

  burst_t burst;
  logic   has_out;
  logic   take;

  assign take = in_valid && in_ready;

  drle_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .take       (take),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .burst      (burst),
    .has_out    (has_out)
  );

  drle_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load       (take && has_out),
    .burst      (burst),
    .can_take   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .burst_end  (burst_end),
    .stream_end (stream_end)
  );

endmodule

// File: rtl/drle_checker.sv
// Port-level checks on the encoder, bound to the top level.
module drle_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [drle_pkg::BYTE_W-1:0] out_byte,
  input logic                        burst_end,
  input logic                        stream_end
);
  import drle_pkg::*;

  // A held output beat must not change while it waits.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(burst_end) &&
                                $stable(stream_end))
    else $error("output beat changed while stalled");

  // The end of a stream is always the end of a burst.
  a_stream_in_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> burst_end)
    else $error("stream end without burst end");

  // Reset leaves no output beat pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");

  // With nothing left to send, the block is ready for a new input.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_ready && burst_end) && !out_valid && !$past(in_valid && in_ready)
    |-> in_ready)
    else $error("input stalled with nothing to send");

endmodule

bind delta_rle_encoder drle_checker u_drle_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .burst_end  (burst_end),
  .stream_end (stream_end)
);

// File: dv/delta_rle_encoder_tb.sv
// Self-checking testbench for the delta plus escaped run-length encoder.
`timescale 1ns / 1ps

module delta_rle_encoder_tb;
  import drle_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [BYTE_W-1:0] ESC_ZERO  = 8'h00;
  localparam logic [BYTE_W-1:0] STEP_DOWN = 8'hFF;
  localparam logic [SPAN_W-1:0] SPAN_MAX  = 21'h1FFFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              burst_last;
    logic              stream_last;
  } enc_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [SPAN_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              final_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              burst_end;
  logic              stream_end;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_req    = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;
  int   errors      = 0;
  int   quiet_count = 0;

  // Encoder state as the checker believes it to be.
  logic              enc_started;
  logic [BYTE_W-1:0] enc_prev_raw;
  logic [BYTE_W-1:0] enc_run_val;
  logic [BYTE_W-1:0] enc_run_len;
  logic              enc_chunk_sent;
  logic [SPAN_W-1:0] enc_pos;
  logic [SPAN_W-1:0] enc_span;

  logic [BYTE_W-1:0] burst_bytes[$];
  enc_beat_t         expected_beats[$];
  enc_beat_t         want_beat;

  delta_rle_encoder u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .burst_end  (burst_end),
    .stream_end (stream_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_stream_state();
    enc_started    = 1'b0;
    enc_prev_raw   = '0;
    enc_run_val    = '0;
    enc_run_len    = '0;
    enc_chunk_sent = 1'b0;
    enc_pos        = '0;
  endfunction

  // Emits the pending run: as a marked group once it is long enough or a chunk
  // of it has gone out, otherwise as literals with the mark byte escaped.
  function automatic void emit_pending_run();
    if (enc_chunk_sent || enc_run_len >= MIN_RUN) begin
      if (enc_run_len != '0) begin
        burst_bytes.push_back(RUN_MARK);
        burst_bytes.push_back(enc_run_len);
        burst_bytes.push_back(enc_run_val);
      end
    end else begin
      for (int k = 0; k < int'(enc_run_len); k++) begin
        if (enc_run_val == RUN_MARK) begin
          burst_bytes.push_back(RUN_MARK);
          burst_bytes.push_back(ESC_ZERO);
          burst_bytes.push_back(RUN_MARK);
        end else begin
          burst_bytes.push_back(enc_run_val);
        end
      end
    end
    enc_run_len    = '0;
    enc_chunk_sent = 1'b0;
  endfunction

  function automatic void encode_byte(logic [BYTE_W-1:0] raw, logic fin);
    logic [BYTE_W-1:0] coded;
    burst_bytes.delete();
    if (!enc_started) begin
      enc_started    = 1'b1;
      enc_prev_raw   = raw;
      enc_run_val    = raw;
      enc_run_len    = 8'd1;
      enc_chunk_sent = 1'b0;
      if (enc_pos < enc_span) enc_pos = enc_pos + 1'b1;
    end else begin
      if (enc_pos < enc_span) begin
        coded        = raw - enc_prev_raw;
        enc_prev_raw = raw;
        enc_pos      = enc_pos + 1'b1;
      end else begin
        coded = raw;
      end
      if (coded == enc_run_val) begin
        enc_run_len = enc_run_len + 1'b1;
      end else begin
        emit_pending_run();
        enc_run_val = coded;
        enc_run_len = 8'd1;
      end
      if (enc_run_len == CHUNK_MAX) begin
        burst_bytes.push_back(RUN_MARK);
        burst_bytes.push_back(CHUNK_MAX);
        burst_bytes.push_back(enc_run_val);
        enc_run_len    = '0;
        enc_chunk_sent = 1'b1;
      end
    end
    if (fin) begin
      emit_pending_run();
      clear_stream_state();
    end
    foreach (burst_bytes[i]) begin
      expected_beats.push_back('{code:        burst_bytes[i],
                                 burst_last:  (i == burst_bytes.size() - 1),
                                 stream_last: fin && (i == burst_bytes.size() - 1)});
    end
  endfunction

  // Predicts on every accepted input beat and checks every accepted output beat.
  always @(posedge clk) begin
    if (rst) begin
      enc_span = SPAN_RESET;
      clear_stream_state();
      expected_beats.delete();
    end else begin
      if (cfg_we) enc_span = cfg_data;
      if (in_valid && in_ready) encode_byte(data_byte, final_byte);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("out_byte: no beat expected, got %02h", out_byte);
          errors++;
        end else begin
          want_beat = expected_beats.pop_front();
          if (out_byte !== want_beat.code) begin
            $error("out_byte: expected %02h, got %02h", want_beat.code, out_byte);
            errors++;
          end
          if (burst_end !== want_beat.burst_last) begin
            $error("burst_end: expected %0b, got %0b", want_beat.burst_last, burst_end);
            errors++;
          end
          if (stream_end !== want_beat.stream_last) begin
            $error("stream_end: expected %0b, got %0b", want_beat.stream_last, stream_end);
            errors++;
          end
        end
      end
    end
  end

  // Output side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= value;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops sending and waits until every expected beat has arrived and the
  // encoder has had time to finish any beat that produced no output.
  task automatic settle();
    int calm;
    calm = 0;
    in_valid <= 1'b0;
    while (calm < SETTLE_CYCLES) begin
      @(posedge clk);
      if (expected_beats.size() == 0) calm++;
      else calm = 0;
    end
  endtask

  task automatic write_span(input logic [SPAN_W-1:0] span);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= span;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic test_directed();
    // A stream of a single byte, then a single mark byte that must be escaped.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Three deltas of 0xFF give three escaped literals, then a short zero run.
    send_byte(8'h10, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h0E, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h0D, 1'b1);
    // Five zero deltas form a marked group at the end of the stream.
    repeat (5) send_byte(8'h42, 1'b0);
    send_byte(8'h42, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_span_settings();
    logic [SPAN_W-1:0] spans[6];
    spans = '{21'd0, 21'd1, 21'd2, 21'd3, SPAN_MAX, SPAN_RESET};
    foreach (spans[i]) begin
      write_span(spans[i]);
      send_byte(8'h20, 1'b0);
      send_byte(8'h21, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h23, 1'b1);
    end
    // Span lowered in the middle of a stream takes hold from the next byte.
    send_byte(8'h30, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(8'h32, 1'b0);
    write_span(21'd1);
    send_byte(8'h33, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  task automatic test_chunked_runs();
    write_span(21'd0);
    // One byte past a full chunk: the chunk goes out at once and the lone
    // leftover byte still follows as a marked group.
    for (int k = 0; k < 256; k++) send_byte(8'hFF, k == 255);
    write_span(SPAN_RESET);
  endtask

  task automatic test_backpressure();
    logic [BYTE_W-1:0] base;
    base     = BYTE_W'($urandom);
    hold_req = ~hold_req;
    // Alternating deltas of 0xFF and 0x01 make each beat after the first flush a run of one, every other one an escape.
    for (int k = 0; k < 20; k++) send_byte((k % 2) ? base - 1'b1 : base, k == 19);
    settle();
  endtask

  task automatic test_random_streams(input int count);
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] step;
    logic [SPAN_W-1:0] span;
    int                left;
    int                seg_len;
    int                stream_left;
    cur         = BYTE_W'($urandom);
    stream_left = $urandom_range(1, 24);
    for (int part = 0; part < 3; part++) begin
      case ($urandom_range(7))
        0:       span = 21'd0;
        1:       span = 21'd1;
        2:       span = SPAN_W'($urandom_range(2, 40));
        3:       span = SPAN_MAX;
        default: span = SPAN_RESET;
      endcase
      write_span(span);
      left = count / 3;
      while (left > 0) begin
        case ($urandom_range(5))
          0, 1:    step = '0;
          2:       step = STEP_DOWN;
          3:       step = 8'h01;
          default: step = BYTE_W'($urandom);
        endcase
        seg_len = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
        for (int k = 0; k < seg_len && left > 0; k++) begin
          cur = cur + step;
          stream_left--;
          send_byte(cur, stream_left == 0);
          if (stream_left == 0) stream_left = $urandom_range(1, 24);
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 30;
    rx_idle_pct = 67;
    test_directed();
    test_span_settings();
    test_random_streams(18);

    tx_idle_pct = 67;
    rx_idle_pct = 30;
    test_chunked_runs();
    test_random_streams(18);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_streams(18);
    send_byte(8'h00, 1'b1);

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
